### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL of the IGC record parser, used by igc_queue.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is high
`define IGC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, including during reset
`define IGC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/igc_pkg.sv
// ----------------------------------------------------------------------------
// igc_pkg
// Shared types, character codes, field layout and decoders for the IGC
// record parser.
// ----------------------------------------------------------------------------
package igc_pkg;

   // default record limit (a record holds at most RECORD_LIMIT - 1 bytes, newline included)
   localparam int RECORD_LIMIT_DEF = 50;

   // position index width; covers record limits up to 256
   localparam int POS_W = 8;

   // record lengths
   localparam int B_LEN = 35;
   localparam int H_LEN = 11;

   // field accumulators
   localparam int ACC_W      = 17;
   localparam int NUM_FIELDS = 14;
   localparam int FIELD_W    = $clog2(NUM_FIELDS);

   // queue between front and back
   localparam int Q_DEPTH = 2;

   // result widths
   localparam int TIME_W    = 7;
   localparam int LAT_W     = 24;
   localparam int LON_W     = 27;
   localparam int ALT_W     = 18;
   localparam int YEAR_W    = 12;
   localparam int LAT_MAG_W = 23;
   localparam int LON_MAG_W = 26;
   localparam int LO_W      = 17;
   localparam int LAT_DEG_W = 7;
   localparam int LON_DEG_W = 10;
   localparam int THOU_W    = 10;

   // scaling to thousandths of an arc minute
   localparam int DEG_SCALE = 60000;
   localparam int MIN_SCALE = 1000;
   localparam int YEAR_BASE = 2000;

   // character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_B     = 8'h42;
   localparam logic [7:0] CH_D     = 8'h44;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_W     = 8'h57;

   // B record field indices
   localparam logic [FIELD_W-1:0] F_HOUR     = 4'd0;
   localparam logic [FIELD_W-1:0] F_MIN      = 4'd1;
   localparam logic [FIELD_W-1:0] F_SEC      = 4'd2;
   localparam logic [FIELD_W-1:0] F_LAT_DEG  = 4'd3;
   localparam logic [FIELD_W-1:0] F_LAT_MIN  = 4'd4;
   localparam logic [FIELD_W-1:0] F_LAT_THOU = 4'd5;
   localparam logic [FIELD_W-1:0] F_LAT_HEMI = 4'd6;
   localparam logic [FIELD_W-1:0] F_LON_DEG  = 4'd7;
   localparam logic [FIELD_W-1:0] F_LON_MIN  = 4'd8;
   localparam logic [FIELD_W-1:0] F_LON_THOU = 4'd9;
   localparam logic [FIELD_W-1:0] F_LON_HEMI = 4'd10;
   localparam logic [FIELD_W-1:0] F_VALIDITY = 4'd11;
   localparam logic [FIELD_W-1:0] F_PALT     = 4'd12;
   localparam logic [FIELD_W-1:0] F_GALT     = 4'd13;

   // H record field indices
   localparam logic [FIELD_W-1:0] F_DAY   = 4'd0;
   localparam logic [FIELD_W-1:0] F_MONTH = 4'd1;
   localparam logic [FIELD_W-1:0] F_YEAR  = 4'd2;

   // special positions
   localparam logic [POS_W-1:0] POS_PALT_SIGN = 8'd25;
   localparam logic [POS_W-1:0] POS_GALT_SIGN = 8'd30;
   localparam logic [POS_W-1:0] POS_H_SUB     = 8'd1;
   localparam logic [POS_W-1:0] POS_DTE_LAST  = 8'd4;

   // result kinds
   localparam logic KIND_FIX  = 1'b0;
   localparam logic KIND_DATE = 1'b1;

   typedef enum logic [1:0] {
      REC_NONE = 2'd0,
      REC_B    = 2'd1,
      REC_H    = 2'd2
   } rec_kind_type;

   // one closed record, as handed from front to back
   typedef struct packed {
      logic                 kind;
      logic [TIME_W-1:0]    hour;
      logic [TIME_W-1:0]    minute;
      logic [TIME_W-1:0]    second;
      logic [LAT_DEG_W-1:0] lat_deg;
      logic [TIME_W-1:0]    lat_min;
      logic [THOU_W-1:0]    lat_thou;
      logic                 south;
      logic [LON_DEG_W-1:0] lon_deg;
      logic [TIME_W-1:0]    lon_min;
      logic [THOU_W-1:0]    lon_thou;
      logic                 west;
      logic [ACC_W-1:0]     alt_mag;
      logic                 alt_neg;
      logic [TIME_W-1:0]    day;
      logic [TIME_W-1:0]    month;
      logic [TIME_W-1:0]    year_lo;
   } rec_type;

   // B record: byte position to field index
   function automatic logic [FIELD_W-1:0] b_field(input logic [POS_W-1:0] pos);
      logic [FIELD_W-1:0] f;
      unique case (pos) inside
         [8'd1:8'd2]:   f = F_HOUR;
         [8'd3:8'd4]:   f = F_MIN;
         [8'd5:8'd6]:   f = F_SEC;
         [8'd7:8'd8]:   f = F_LAT_DEG;
         [8'd9:8'd10]:  f = F_LAT_MIN;
         [8'd11:8'd13]: f = F_LAT_THOU;
         8'd14:         f = F_LAT_HEMI;
         [8'd15:8'd17]: f = F_LON_DEG;
         [8'd18:8'd19]: f = F_LON_MIN;
         [8'd20:8'd22]: f = F_LON_THOU;
         8'd23:         f = F_LON_HEMI;
         8'd24:         f = F_VALIDITY;
         [8'd25:8'd29]: f = F_PALT;
         [8'd30:8'd34]: f = F_GALT;
         default:       f = F_HOUR;
      endcase
      return f;
   endfunction

   // H record: date digit position to field index
   function automatic logic [FIELD_W-1:0] h_field(input logic [POS_W-1:0] pos);
      logic [FIELD_W-1:0] f;
      unique case (pos) inside
         [8'd5:8'd6]:  f = F_DAY;
         [8'd7:8'd8]:  f = F_MONTH;
         [8'd9:8'd10]: f = F_YEAR;
         default:      f = F_DAY;
      endcase
      return f;
   endfunction

   // H record: expected subtype letter
   function automatic logic [7:0] dte_char(input logic [POS_W-1:0] pos);
      logic [7:0] ch;
      unique case (pos)
         8'd2:    ch = CH_D;
         8'd3:    ch = CH_T;
         8'd4:    ch = CH_E;
         default: ch = CH_NUL;
      endcase
      return ch;
   endfunction

endpackage

### rtl/igc_front.sv
// ----------------------------------------------------------------------------
// igc_front
// Byte front end: tracks the record position, classifies each byte, builds
// the numeric fields by shift-add and hands a closed, well-formed record on.
// ----------------------------------------------------------------------------
module igc_front #(
   parameter int RECORD_LIMIT = igc_pkg::RECORD_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_data,
   input  logic             alt_src,
   input  logic             q_full,
   output logic             push,
   output igc_pkg::rec_type entry
);
   import igc_pkg::*;

   localparam int CNT_W = $clog2(RECORD_LIMIT);

   logic [CNT_W-1:0] pos_ff, pos_in;
   rec_kind_type     kind_ff, kind_cur;
   logic [1:0]       sub_ff, sub_in;
   logic [1:0]       hemi_ff, hemi_in;
   logic [1:0]       sign_ff, sign_in;
   logic             fmt_ff, fmt_in;
   logic [ACC_W-1:0] acc_ff [NUM_FIELDS];
   logic [ACC_W-1:0] acc_in [NUM_FIELDS];

   logic [POS_W-1:0]   pos8;
   logic [7:0]         ch;
   logic [7:0]         digit_v;
   logic               is_digit;
   logic               dig_en;
   logic [FIELD_W-1:0] dig_idx;
   logic [FIELD_W-1:0] fld;
   logic               accept;
   logic               close;
   logic               emit_b;
   logic               emit_h;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign ch        = req_data_byte;
   assign pos8      = POS_W'(pos_ff);
   assign pos_in    = pos_ff + 1'b1;

   // byte classification and field update
   always_comb begin
      kind_cur = kind_ff;
      sub_in   = sub_ff;
      hemi_in  = hemi_ff;
      sign_in  = sign_ff;
      fmt_in   = fmt_ff;
      acc_in   = acc_ff;
      dig_en   = 1'b0;
      dig_idx  = F_HOUR;
      fld      = b_field(pos8);
      digit_v  = ch - CH_0;
      is_digit = (ch >= CH_0) && (ch <= CH_9);

      if (pos_ff == '0) begin
         if (ch == CH_B) begin
            kind_cur = REC_B;
         end else if (ch == CH_H) begin
            kind_cur = REC_H;
         end else begin
            kind_cur = REC_NONE;
         end
      end else if (kind_ff == REC_B && pos8 < POS_W'(B_LEN)) begin
         if (fld == F_LAT_HEMI || fld == F_LON_HEMI || fld == F_VALIDITY) begin
            if (ch == CH_NUL) begin
               fmt_in = 1'b0;
            end else if (fld == F_LAT_HEMI && ch == CH_S) begin
               hemi_in[0] = 1'b1;
            end else if (fld == F_LON_HEMI && ch == CH_W) begin
               hemi_in[1] = 1'b1;
            end
         end else if (pos8 == POS_PALT_SIGN || pos8 == POS_GALT_SIGN) begin
            // leading sign of an altitude field
            if (ch == CH_MINUS) begin
               if (pos8 == POS_PALT_SIGN) begin
                  sign_in[0] = 1'b1;
               end else begin
                  sign_in[1] = 1'b1;
               end
            end else if (ch != CH_PLUS) begin
               dig_en  = 1'b1;
               dig_idx = fld;
            end
         end else begin
            dig_en  = 1'b1;
            dig_idx = fld;
         end
      end else if (kind_ff == REC_H && pos8 < POS_W'(H_LEN)) begin
         if (pos8 == POS_H_SUB) begin
            if (ch == CH_NUL) begin
               fmt_in = 1'b0;
            end
         end else if (pos8 <= POS_DTE_LAST) begin
            if (ch == dte_char(pos8)) begin
               sub_in = sub_ff + 2'd1;
            end else begin
               fmt_in = 1'b0;
            end
         end else begin
            dig_en  = 1'b1;
            dig_idx = h_field(pos8);
         end
      end

      // decimal shift-add
      if (dig_en) begin
         if (is_digit) begin
            acc_in[dig_idx] = (acc_ff[dig_idx] << 3) + (acc_ff[dig_idx] << 1)
                              + ACC_W'(digit_v[3:0]);
         end else begin
            fmt_in = 1'b0;
         end
      end
   end

   // record close and result decision
   assign close  = (ch == CH_LF) || req_end_of_data || (pos_ff == CNT_W'(RECORD_LIMIT - 2));
   assign emit_b = (kind_cur == REC_B) && fmt_in && (pos8 >= POS_W'(B_LEN - 1));
   assign emit_h = (kind_cur == REC_H) && fmt_in && (sub_in == 2'd3)
                   && (pos8 >= POS_W'(H_LEN - 1));
   assign push   = accept && close && (emit_b || emit_h);

   // queue entry, taken from the updated fields
   always_comb begin
      entry = '0;
      if (kind_cur == REC_B) begin
         entry.kind     = KIND_FIX;
         entry.hour     = acc_in[F_HOUR][TIME_W-1:0];
         entry.minute   = acc_in[F_MIN][TIME_W-1:0];
         entry.second   = acc_in[F_SEC][TIME_W-1:0];
         entry.lat_deg  = acc_in[F_LAT_DEG][LAT_DEG_W-1:0];
         entry.lat_min  = acc_in[F_LAT_MIN][TIME_W-1:0];
         entry.lat_thou = acc_in[F_LAT_THOU][THOU_W-1:0];
         entry.south    = hemi_in[0];
         entry.lon_deg  = acc_in[F_LON_DEG][LON_DEG_W-1:0];
         entry.lon_min  = acc_in[F_LON_MIN][TIME_W-1:0];
         entry.lon_thou = acc_in[F_LON_THOU][THOU_W-1:0];
         entry.west     = hemi_in[1];
         entry.alt_mag  = alt_src ? acc_in[F_GALT] : acc_in[F_PALT];
         entry.alt_neg  = alt_src ? sign_in[1] : sign_in[0];
      end else begin
         entry.kind    = KIND_DATE;
         entry.day     = acc_in[F_DAY][TIME_W-1:0];
         entry.month   = acc_in[F_MONTH][TIME_W-1:0];
         entry.year_lo = acc_in[F_YEAR][TIME_W-1:0];
      end
   end

   // record state
   always_ff @(posedge clock) begin
      if (reset || (accept && close)) begin
         pos_ff  <= '0;
         kind_ff <= REC_NONE;
         sub_ff  <= '0;
         hemi_ff <= '0;
         sign_ff <= '0;
         fmt_ff  <= 1'b1;
         for (int i = 0; i < NUM_FIELDS; i++) begin
            acc_ff[i] <= '0;
         end
      end else if (accept) begin
         pos_ff  <= pos_in;
         kind_ff <= kind_cur;
         sub_ff  <= sub_in;
         hemi_ff <= hemi_in;
         sign_ff <= sign_in;
         fmt_ff  <= fmt_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

### rtl/igc_queue.sv
// ----------------------------------------------------------------------------
// igc_queue
// Short FIFO of closed records between the byte front end and the result
// back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module igc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_i,
   input  igc_pkg::rec_type entry_i,
   output logic             full_o,
   input  logic             pop_i,
   output logic             valid_o,
   output igc_pkg::rec_type entry_o
);
   import igc_pkg::*;

   localparam int PTR_W = $clog2(Q_DEPTH);
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   rec_type          mem_ff [Q_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full_o  = (count_ff == CNT_W'(Q_DEPTH));
   assign valid_o = (count_ff != '0);
   assign entry_o = mem_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_i) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_i) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[wr_ptr_ff] <= entry_i;
      end
   end

   // checks
   `IGC_ASSERT(a_no_overflow, clock, reset, push_i |-> (count_ff != CNT_W'(Q_DEPTH)), "queue push while full")
   `IGC_ASSERT(a_no_underflow, clock, reset, pop_i |-> (count_ff != '0), "queue pop while empty")
   `IGC_ASSERT(a_fill_step, clock, reset, (push_i && !pop_i) |=> (count_ff == $past(count_ff) + 1'b1), "queue fill count did not step")

endmodule

### rtl/igc_back.sv
// ----------------------------------------------------------------------------
// igc_back
// Result back end: scales degrees and minutes, then sums, applies the
// hemisphere and altitude signs and holds the result beat for the receiver.
// ----------------------------------------------------------------------------
module igc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  igc_pkg::rec_type                  q_entry,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [igc_pkg::TIME_W-1:0]        rsp_hour,
   output logic [igc_pkg::TIME_W-1:0]        rsp_minute,
   output logic [igc_pkg::TIME_W-1:0]        rsp_second,
   output logic signed [igc_pkg::LAT_W-1:0]  rsp_latitude,
   output logic signed [igc_pkg::LON_W-1:0]  rsp_longitude,
   output logic signed [igc_pkg::ALT_W-1:0]  rsp_altitude,
   output logic [igc_pkg::TIME_W-1:0]        rsp_day,
   output logic [igc_pkg::TIME_W-1:0]        rsp_month,
   output logic [igc_pkg::YEAR_W-1:0]        rsp_year
);
   import igc_pkg::*;

   // partial products of one record
   typedef struct packed {
      logic                 kind;
      logic [TIME_W-1:0]    hour;
      logic [TIME_W-1:0]    minute;
      logic [TIME_W-1:0]    second;
      logic [LAT_MAG_W-1:0] lat_hi;
      logic [LO_W-1:0]      lat_lo;
      logic                 south;
      logic [LON_MAG_W-1:0] lon_hi;
      logic [LO_W-1:0]      lon_lo;
      logic                 west;
      logic [ACC_W-1:0]     alt_mag;
      logic                 alt_neg;
      logic [TIME_W-1:0]    day;
      logic [TIME_W-1:0]    month;
      logic [YEAR_W-1:0]    year;
   } scaled_type;

   scaled_type       st_ff, st_in;
   logic             st_valid_ff, st_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             adv;
   logic [LAT_MAG_W-1:0] lat_sum;
   logic [LON_MAG_W-1:0] lon_sum;
   logic [LAT_W-1:0]     lat_ext;
   logic [LON_W-1:0]     lon_ext;
   logic [ALT_W-1:0]     alt_ext;

   logic                     rsp_kind_ff;
   logic [TIME_W-1:0]        rsp_hour_ff, rsp_minute_ff, rsp_second_ff;
   logic signed [LAT_W-1:0]  rsp_latitude_ff;
   logic signed [LON_W-1:0]  rsp_longitude_ff;
   logic signed [ALT_W-1:0]  rsp_altitude_ff;
   logic [TIME_W-1:0]        rsp_day_ff, rsp_month_ff;
   logic [YEAR_W-1:0]        rsp_year_ff;

   // handshake between the two stages
   assign adv          = st_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop          = q_valid && (!st_valid_ff || adv);
   assign st_valid_in  = pop ? 1'b1 : (adv ? 1'b0 : st_valid_ff);
   assign rsp_valid_in = adv ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   // stage one: constant scaling
   always_comb begin
      st_in.kind    = q_entry.kind;
      st_in.hour    = q_entry.hour;
      st_in.minute  = q_entry.minute;
      st_in.second  = q_entry.second;
      st_in.lat_hi  = LAT_MAG_W'(q_entry.lat_deg) * LAT_MAG_W'(DEG_SCALE);
      st_in.lat_lo  = LO_W'(q_entry.lat_min) * LO_W'(MIN_SCALE) + LO_W'(q_entry.lat_thou);
      st_in.south   = q_entry.south;
      st_in.lon_hi  = LON_MAG_W'(q_entry.lon_deg) * LON_MAG_W'(DEG_SCALE);
      st_in.lon_lo  = LO_W'(q_entry.lon_min) * LO_W'(MIN_SCALE) + LO_W'(q_entry.lon_thou);
      st_in.west    = q_entry.west;
      st_in.alt_mag = q_entry.alt_mag;
      st_in.alt_neg = q_entry.alt_neg;
      st_in.day     = q_entry.day;
      st_in.month   = q_entry.month;
      st_in.year    = (q_entry.kind == KIND_DATE)
                      ? YEAR_W'(q_entry.year_lo) + YEAR_W'(YEAR_BASE) : '0;
   end

   // stage two: sum and sign
   assign lat_sum = st_ff.lat_hi + LAT_MAG_W'(st_ff.lat_lo);
   assign lon_sum = st_ff.lon_hi + LON_MAG_W'(st_ff.lon_lo);
   assign lat_ext = LAT_W'(lat_sum);
   assign lon_ext = LON_W'(lon_sum);
   assign alt_ext = ALT_W'(st_ff.alt_mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         st_ff <= st_in;
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_kind_ff      <= st_ff.kind;
         rsp_hour_ff      <= st_ff.hour;
         rsp_minute_ff    <= st_ff.minute;
         rsp_second_ff    <= st_ff.second;
         rsp_latitude_ff  <= $signed(st_ff.south ? (LAT_W'(0) - lat_ext) : lat_ext);
         rsp_longitude_ff <= $signed(st_ff.west ? (LON_W'(0) - lon_ext) : lon_ext);
         rsp_altitude_ff  <= $signed(st_ff.alt_neg ? (ALT_W'(0) - alt_ext) : alt_ext);
         rsp_day_ff       <= st_ff.day;
         rsp_month_ff     <= st_ff.month;
         rsp_year_ff      <= st_ff.year;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_hour      = rsp_hour_ff;
   assign rsp_minute    = rsp_minute_ff;
   assign rsp_second    = rsp_second_ff;
   assign rsp_latitude  = rsp_latitude_ff;
   assign rsp_longitude = rsp_longitude_ff;
   assign rsp_altitude  = rsp_altitude_ff;
   assign rsp_day       = rsp_day_ff;
   assign rsp_month     = rsp_month_ff;
   assign rsp_year      = rsp_year_ff;

endmodule

### rtl/igc_record_parser.sv
// ----------------------------------------------------------------------------
// igc_record_parser
// IGC flight log parser: turns a byte stream into position fix and flight
// date results.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one log byte per beat, req_end_of_data closes the last record.
//   rsp_*  : one beat per well-formed B record (fix) or H record of subtype DTE
//            (date); malformed or other records give no beat.
//   csr_*  : altitude_source, written while the block is idle; reset value 1
//            (GPS altitude), 0 selects pressure altitude.
// Throughput: one byte per cycle while req_stall is low; a record may close every cycle.
// The result beat of a record passes through the record queue, the constant
//   scaling stage and the output register after the byte that closes the
//   record is accepted; a held rsp_stall can delay it at each of these.
// A two-entry record queue sits between front and back. req_stall rises only
//   while that queue is full, which happens when the receiver holds
//   rsp_stall and records keep closing; bytes inside a record still stream
//   in until then.
// Reset (synchronous) empties the queue and pipeline and starts a new record.
// ----------------------------------------------------------------------------
module igc_record_parser #(
   parameter int RECORD_LIMIT = igc_pkg::RECORD_LIMIT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_end_of_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_kind,
   output logic [igc_pkg::TIME_W-1:0]        rsp_hour,
   output logic [igc_pkg::TIME_W-1:0]        rsp_minute,
   output logic [igc_pkg::TIME_W-1:0]        rsp_second,
   output logic signed [igc_pkg::LAT_W-1:0]  rsp_latitude,
   output logic signed [igc_pkg::LON_W-1:0]  rsp_longitude,
   output logic signed [igc_pkg::ALT_W-1:0]  rsp_altitude,
   output logic [igc_pkg::TIME_W-1:0]        rsp_day,
   output logic [igc_pkg::TIME_W-1:0]        rsp_month,
   output logic [igc_pkg::YEAR_W-1:0]        rsp_year,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data
);
   import igc_pkg::*;

   logic    alt_src_ff;
   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_valid;
   rec_type push_entry;
   rec_type head_entry;

   // altitude source register
   always_ff @(posedge clock) begin
      if (reset) begin
         alt_src_ff <= 1'b1;
      end else if (csr_wr_en) begin
         alt_src_ff <= csr_wr_data;
      end
   end

   igc_front #(
      .RECORD_LIMIT (RECORD_LIMIT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .alt_src         (alt_src_ff),
      .q_full          (q_full),
      .push            (q_push),
      .entry           (push_entry)
   );

   igc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (q_push),
      .entry_i (push_entry),
      .full_o  (q_full),
      .pop_i   (q_pop),
      .valid_o (q_valid),
      .entry_o (head_entry)
   );

   igc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_entry       (head_entry),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_hour      (rsp_hour),
      .rsp_minute    (rsp_minute),
      .rsp_second    (rsp_second),
      .rsp_latitude  (rsp_latitude),
      .rsp_longitude (rsp_longitude),
      .rsp_altitude  (rsp_altitude),
      .rsp_day       (rsp_day),
      .rsp_month     (rsp_month),
      .rsp_year      (rsp_year)
   );

endmodule

### tb/tb_igc_record_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_igc_record_parser
// Self-checking bench for the IGC record parser. Log bytes are streamed in
// with random gaps while the result side stalls at random. A predictor
// follows every accepted byte, queues the fix or date it should produce, and
// each result beat is compared field by field with the oldest entry.
// Directed records cover field extremes and malformed input; a random log
// then mixes well-formed, broken and noise records across altitude settings.
// ----------------------------------------------------------------------------
module tb_igc_record_parser;
   import igc_pkg::*;

   localparam int HALF_PERIOD    = 6;
   localparam int RESET_CYCLES   = 11;
   localparam int DRAIN_CYCLES   = 8;
   localparam int QUIET_LIMIT    = 400;
   localparam int MAX_WAIT       = 4;
   localparam int RANDOM_BYTES   = 480;
   localparam int RANDOM_REPORTS = 8;

   typedef logic [7:0] log_bytes_type [$];

   // one expected fix or date
   typedef struct {
      logic                     kind;
      logic [TIME_W-1:0]        hour;
      logic [TIME_W-1:0]        minute;
      logic [TIME_W-1:0]        second;
      logic signed [LAT_W-1:0]  latitude;
      logic signed [LON_W-1:0]  longitude;
      logic signed [ALT_W-1:0]  altitude;
      logic [TIME_W-1:0]        day;
      logic [TIME_W-1:0]        month;
      logic [YEAR_W-1:0]        year;
   } log_report_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [7:0]               req_data_byte;
   logic                     req_end_of_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic                     rsp_kind;
   logic [TIME_W-1:0]        rsp_hour;
   logic [TIME_W-1:0]        rsp_minute;
   logic [TIME_W-1:0]        rsp_second;
   logic signed [LAT_W-1:0]  rsp_latitude;
   logic signed [LON_W-1:0]  rsp_longitude;
   logic signed [ALT_W-1:0]  rsp_altitude;
   logic [TIME_W-1:0]        rsp_day;
   logic [TIME_W-1:0]        rsp_month;
   logic [YEAR_W-1:0]        rsp_year;
   logic                     csr_wr_en;
   logic                     csr_wr_data;

   // bench bookkeeping
   log_report_type expected_reports [$];
   int  mismatches        = 0;
   int  reports_predicted = 0;
   int  quiet_cycles      = 0;
   bit  feed_steady       = 1'b0;
   bit  drain_steady      = 1'b0;

   // predictor copy of the parser state
   bit           gps_altitude;
   int unsigned  rec_pos;
   rec_kind_type rec_kind;
   int           dte_hits;
   int unsigned  acc [NUM_FIELDS];
   bit           south, west, palt_neg, galt_neg;
   bit           fmt_ok;

   igc_record_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_end_of_data (req_end_of_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_hour        (rsp_hour),
      .rsp_minute      (rsp_minute),
      .rsp_second      (rsp_second),
      .rsp_latitude    (rsp_latitude),
      .rsp_longitude   (rsp_longitude),
      .rsp_altitude    (rsp_altitude),
      .rsp_day         (rsp_day),
      .rsp_month       (rsp_month),
      .rsp_year        (rsp_year),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void clear_record_state();
      rec_pos  = 0;
      rec_kind = REC_NONE;
      dte_hits = 0;
      foreach (acc[i]) acc[i] = 0;
      south    = 1'b0;
      west     = 1'b0;
      palt_neg = 1'b0;
      galt_neg = 1'b0;
      fmt_ok   = 1'b1;
   endfunction

   // which B record field a byte position feeds
   function automatic int fix_field_at(input int unsigned p);
      if (p <= 2)  return F_HOUR;
      if (p <= 4)  return F_MIN;
      if (p <= 6)  return F_SEC;
      if (p <= 8)  return F_LAT_DEG;
      if (p <= 10) return F_LAT_MIN;
      if (p <= 13) return F_LAT_THOU;
      if (p == 14) return F_LAT_HEMI;
      if (p <= 17) return F_LON_DEG;
      if (p <= 19) return F_LON_MIN;
      if (p <= 22) return F_LON_THOU;
      if (p == 23) return F_LON_HEMI;
      if (p == 24) return F_VALIDITY;
      if (p <= 29) return F_PALT;
      return F_GALT;
   endfunction

   function automatic void add_digit(input int field, input logic [7:0] ch);
      if (ch >= CH_0 && ch <= CH_9)
         acc[field] = acc[field] * 10 + (ch - CH_0);
      else
         fmt_ok = 1'b0;
   endfunction

   function automatic void predict_log_byte(input logic [7:0] ch, input logic last);
      int unsigned p;
      int          field;
      longint      lat, lon, alt;
      int unsigned yr;
      log_report_type rep;
      p = rec_pos;
      if (p == 0) begin
         rec_kind = (ch == CH_B) ? REC_B : (ch == CH_H) ? REC_H : REC_NONE;
      end else if (rec_kind == REC_B && p < B_LEN) begin
         field = fix_field_at(p);
         if (field == F_LAT_HEMI || field == F_LON_HEMI || field == F_VALIDITY) begin
            if (ch == CH_NUL)
               fmt_ok = 1'b0;
            else if (field == F_LAT_HEMI && ch == CH_S)
               south = 1'b1;
            else if (field == F_LON_HEMI && ch == CH_W)
               west = 1'b1;
         end else if (p == POS_PALT_SIGN || p == POS_GALT_SIGN) begin
            // leading sign of an altitude
            if (ch == CH_MINUS) begin
               if (p == POS_PALT_SIGN) palt_neg = 1'b1;
               else                    galt_neg = 1'b1;
            end else if (ch != CH_PLUS) begin
               add_digit(field, ch);
            end
         end else begin
            add_digit(field, ch);
         end
      end else if (rec_kind == REC_H && p < H_LEN) begin
         if (p == POS_H_SUB) begin
            if (ch == CH_NUL) fmt_ok = 1'b0;
         end else if (p <= POS_DTE_LAST) begin
            if (ch == ((p == 2) ? CH_D : (p == 3) ? CH_T : CH_E)) dte_hits++;
            else                                                  fmt_ok = 1'b0;
         end else begin
            add_digit((p - 5) / 2, ch);
         end
      end
      rec_pos++;

      // record closes: newline, end of data or length limit
      if (ch == CH_LF || last || rec_pos >= RECORD_LIMIT_DEF - 1) begin
         rep = '{default: 0};
         if (rec_kind == REC_B && fmt_ok && rec_pos >= B_LEN) begin
            lat = longint'(acc[F_LAT_DEG]) * DEG_SCALE + longint'(acc[F_LAT_MIN]) * MIN_SCALE
                  + longint'(acc[F_LAT_THOU]);
            lon = longint'(acc[F_LON_DEG]) * DEG_SCALE + longint'(acc[F_LON_MIN]) * MIN_SCALE
                  + longint'(acc[F_LON_THOU]);
            alt = longint'(acc[gps_altitude ? F_GALT : F_PALT]);
            if (gps_altitude ? galt_neg : palt_neg) alt = -alt;
            if (south) lat = -lat;
            if (west)  lon = -lon;
            rep.kind      = KIND_FIX;
            rep.hour      = acc[F_HOUR][TIME_W-1:0];
            rep.minute    = acc[F_MIN][TIME_W-1:0];
            rep.second    = acc[F_SEC][TIME_W-1:0];
            rep.latitude  = lat[LAT_W-1:0];
            rep.longitude = lon[LON_W-1:0];
            rep.altitude  = alt[ALT_W-1:0];
            expected_reports.push_back(rep);
            reports_predicted++;
         end else if (rec_kind == REC_H && fmt_ok && dte_hits == 3 && rec_pos >= H_LEN) begin
            yr        = acc[F_YEAR] + YEAR_BASE;
            rep.kind  = KIND_DATE;
            rep.day   = acc[F_DAY][TIME_W-1:0];
            rep.month = acc[F_MONTH][TIME_W-1:0];
            rep.year  = yr[YEAR_W-1:0];
            expected_reports.push_back(rep);
            reports_predicted++;
         end
         clear_record_state();
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result checking and receiver stalls
   // ------------------------------------------------------------------------
   function automatic void compare_field(input string name, input longint want,
                                         input longint got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   function automatic void check_report();
      log_report_type want;
      if (expected_reports.size() == 0) begin
         mismatches++;
         $display("%0t: result beat with none expected (kind %0d)", $time, rsp_kind);
      end else begin
         want = expected_reports.pop_front();
         compare_field("kind",      want.kind,      rsp_kind);
         compare_field("hour",      want.hour,      rsp_hour);
         compare_field("minute",    want.minute,    rsp_minute);
         compare_field("second",    want.second,    rsp_second);
         compare_field("latitude",  want.latitude,  rsp_latitude);
         compare_field("longitude", want.longitude, rsp_longitude);
         compare_field("altitude",  want.altitude,  rsp_altitude);
         compare_field("day",       want.day,       rsp_day);
         compare_field("month",     want.month,     rsp_month);
         compare_field("year",      want.year,      rsp_year);
      end
   endfunction

   // sample mid-cycle, drive stall at the rising edge
   initial begin
      bit got;
      int hold;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         got = !reset && rsp_valid === 1'b1 && !rsp_stall;
         if (got) check_report();
         @(posedge clock);
         if (got) hold = drain_steady ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: no beat on either channel for too long
   always @(negedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: timeout, no beat for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Driving
   // ------------------------------------------------------------------------
   task automatic send_log_byte(input logic [7:0] ch, input logic last);
      int gap;
      bit took;
      gap = feed_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= ch;
      req_end_of_data <= last;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      predict_log_byte(ch, last);
   endtask

   task automatic send_record(input log_bytes_type r, input bit eod_last);
      foreach (r[i]) send_log_byte(r[i], eod_last && i == r.size() - 1);
   endtask

   // drop valid and let every expected result drain out
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_altitude_source(input bit gps);
      // close any open record so the parser is idle
      if (rec_pos != 0) send_log_byte(CH_LF, 1'b0);
      settle_block();
      csr_wr_data <= gps;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gps_altitude = gps;
   endtask

   // ------------------------------------------------------------------------
   // Record builders
   // ------------------------------------------------------------------------
   function automatic void add_text(ref log_bytes_type q, input string s);
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
   endfunction

   function automatic string altitude_text(input int v);
      if (v < 0) return $sformatf("-%04d", -v);
      if (v <= 9999 && $urandom_range(0, 1)) return $sformatf("+%04d", v);
      return $sformatf("%05d", v);
   endfunction

   function automatic log_bytes_type fix_record(input int hh, mm, ss, lat_deg, lat_min,
                                               lat_thou,
                                               input logic [7:0] lat_hemi,
                                               input int lon_deg, lon_min, lon_thou,
                                               input logic [7:0] lon_hemi, validity,
                                               input int palt, galt);
      log_bytes_type r;
      add_text(r, $sformatf("B%02d%02d%02d%02d%02d%03d", hh, mm, ss, lat_deg, lat_min,
                            lat_thou));
      r.push_back(lat_hemi);
      add_text(r, $sformatf("%03d%02d%03d", lon_deg, lon_min, lon_thou));
      r.push_back(lon_hemi);
      r.push_back(validity);
      add_text(r, altitude_text(palt));
      add_text(r, altitude_text(galt));
      return r;
   endfunction

   function automatic log_bytes_type date_record(input logic [7:0] sub, input int dd, mo, yy);
      log_bytes_type r;
      r.push_back(CH_H);
      r.push_back(sub);
      add_text(r, $sformatf("DTE%02d%02d%02d", dd, mo, yy));
      return r;
   endfunction

   // extremes come up often
   function automatic int pick_value(input int top);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return top;
         default: return $urandom_range(0, top);
      endcase
   endfunction

   function automatic logic [7:0] random_marker(input logic [7:0] a, b);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return a;
      if (roll < 8) return b;
      return $urandom_range(1, 255);
   endfunction

   function automatic int random_altitude();
      case ($urandom_range(0, 5))
         0:       return -int'($urandom_range(0, 9999));
         1:       return 99999;
         2:       return -9999;
         default: return $urandom_range(0, 99999);
      endcase
   endfunction

   function automatic log_bytes_type random_fix();
      return fix_record(pick_value(99), pick_value(99), pick_value(99), pick_value(99),
                        pick_value(99), pick_value(999), random_marker(CH_S, "N"),
                        pick_value(999), pick_value(99), pick_value(999),
                        random_marker(CH_W, "E"), random_marker("A", "V"),
                        random_altitude(), random_altitude());
   endfunction

   function automatic log_bytes_type random_date();
      return date_record(random_marker("F", "O"), pick_value(99), pick_value(99),
                         pick_value(99));
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_fix_records();
      log_bytes_type r;
      // largest values, north and east
      r = fix_record(99, 99, 99, 99, 99, 999, "N", 999, 99, 999, "E", "A", 99999, 99999);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // south and west, negative altitudes
      r = fix_record(0, 0, 0, 0, 0, 1, CH_S, 0, 0, 1, CH_W, "V", -9999, -9999);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // all zero
      r = fix_record(0, 0, 0, 0, 0, 0, "N", 0, 0, 0, "E", "A", 0, 0);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // odd bytes in the character fields count as north and east
      r = fix_record(12, 34, 56, 47, 15, 250, 8'hFF, 11, 30, 500, 8'h01, 8'h80, 1500, 1520);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // closed by end of data on the last altitude digit
      r = fix_record(23, 59, 59, 45, 59, 999, CH_S, 179, 59, 999, CH_W, "A", 4321, -12);
      send_record(r, 1'b1);
      // text after the last field is ignored
      r = fix_record(8, 5, 1, 60, 0, 0, "N", 7, 0, 100, CH_W, "A", 87, 99);
      add_text(r, "extra text 123");
      r.push_back(CH_LF);
      send_record(r, 1'b0);
   endtask

   task automatic test_date_records();
      log_bytes_type r;
      r = date_record("F", 1, 1, 0);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      r = date_record("F", 99, 99, 99);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // any non-NUL subtype byte, trailing text ignored
      r = date_record(8'hFF, 31, 12, 25);
      add_text(r, "FLIGHT 1\n");
      send_record(r, 1'b0);
      // closed by end of data on the last year digit
      r = date_record("F", 15, 6, 22);
      send_record(r, 1'b1);
      // NUL subtype byte
      r = date_record(CH_NUL, 1, 2, 3);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // wrong subtype letters
      r = date_record("F", 1, 2, 3);
      r[4] = "X";
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      r = date_record("F", 1, 2, 3);
      r[2] = "d";
      r.push_back(CH_LF);
      send_record(r, 1'b0);
   endtask

   task automatic test_malformed_records();
      log_bytes_type r;
      // short fix
      r = fix_record(1, 2, 3, 4, 5, 6, "N", 7, 8, 9, "E", "A", 10, 11);
      r = r[0:19];
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // space inside a digit field
      r = fix_record(1, 2, 3, 4, 5, 6, "N", 7, 8, 9, "E", "A", 10, 11);
      r[3] = " ";
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // minus sign past the first altitude character
      r = fix_record(1, 2, 3, 4, 5, 6, "N", 7, 8, 9, "E", "A", 12345, 23456);
      r[26] = CH_MINUS;
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // NUL validity byte
      r = fix_record(1, 2, 3, 4, 5, 6, "N", 7, 8, 9, "E", "A", 10, 11);
      r[24] = CH_NUL;
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // newline where the last altitude digit belongs
      r = fix_record(1, 2, 3, 4, 5, 6, "N", 7, 8, 9, "E", "A", 10, 11);
      r[B_LEN-1] = CH_LF;
      send_record(r, 1'b0);
      // unknown first byte, empty line, bare H
      r.delete();
      add_text(r, "LXXXcomment\n\nH\n");
      send_record(r, 1'b0);
      // non-digit in the date
      r = date_record("F", 1, 2, 3);
      r[6] = "a";
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // long line: fix padded to the limit, date follows with no newline
      r = fix_record(14, 0, 7, 46, 2, 345, "N", 8, 12, 678, "E", "A", 2222, 2300);
      repeat (RECORD_LIMIT_DEF - 1 - B_LEN) r.push_back("x");
      add_text(r, "HFDTE150622\n");
      send_record(r, 1'b0);
      // long unknown line
      r.delete();
      r.push_back("I");
      repeat (70) r.push_back(8'hA5);
      r.push_back(CH_LF);
      send_record(r, 1'b0);
      // end of data inside a fix, then a lone B closed by end of data
      r = fix_record(1, 2, 3, 4, 5, 6, "N", 7, 8, 9, "E", "A", 10, 11);
      r = r[0:15];
      send_record(r, 1'b1);
      r.delete();
      r.push_back(CH_B);
      send_record(r, 1'b1);
   endtask

   task automatic test_altitude_source();
      log_bytes_type a, b;
      a = fix_record(10, 20, 30, 51, 30, 123, "N", 0, 7, 456, CH_W, "A", -150, 1200);
      a.push_back(CH_LF);
      b = fix_record(11, 21, 31, 0, 0, 0, CH_S, 180, 0, 0, "E", "V", 99999, -9999);
      b.push_back(CH_LF);
      // pressure altitude
      write_altitude_source(1'b0);
      send_record(a, 1'b0);
      send_record(b, 1'b0);
      // back to GPS altitude
      write_altitude_source(1'b1);
      send_record(a, 1'b0);
      send_record(b, 1'b0);
   endtask

   task automatic test_random_log();
      log_bytes_type r;
      int records, roll, byte_count, first_report;
      bit eod_last, counted;
      records      = 0;
      byte_count   = 0;
      first_report = reports_predicted;
      while (byte_count < RANDOM_BYTES || reports_predicted - first_report < RANDOM_REPORTS)
      begin
         if (records % 12 == 0) write_altitude_source($urandom_range(0, 1));
         feed_steady  = ($urandom_range(0, 3) == 0);
         drain_steady = ($urandom_range(0, 3) == 0);
         roll     = $urandom_range(0, 99);
         eod_last = 1'b0;
         counted  = 1'b1;
         if (roll < 45) begin
            r = random_fix();
         end else if (roll < 60) begin
            r = random_date();
         end else begin
            if ($urandom_range(0, 1)) r = random_fix();
            else                      r = random_date();
            if (roll < 75) begin
               // one byte corrupted
               r[$urandom_range(1, r.size() - 1)] = $urandom_range(0, 255);
            end else if (roll < 83) begin
               r = r[0:$urandom_range(0, r.size() - 2)];
            end else if (roll < 92) begin
               // noise line
               r.delete();
               counted = 1'b0;
               repeat ($urandom_range(1, 60)) r.push_back($urandom_range(0, 255));
            end else begin
               eod_last = 1'b1;
            end
         end
         if (!eod_last && roll < 75 && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 20)) r.push_back($urandom_range(32, 126));
         if (!eod_last) r.push_back(CH_LF);
         if (counted) byte_count += r.size();
         send_record(r, eod_last);
         records++;
      end
      feed_steady  = 1'b0;
      drain_steady = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data_byte   <= '0;
      req_end_of_data <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 1'b0;
      gps_altitude = 1'b1;
      clear_record_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_fix_records();
      test_date_records();
      test_malformed_records();
      test_altitude_source();
      test_random_log();

      settle_block();
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/igc_pkg.sv
rtl/igc_front.sv
rtl/igc_queue.sv
rtl/igc_back.sv
rtl/igc_record_parser.sv
tb/tb_igc_record_parser.sv
